// ===== design/cfs_pkg.sv =====
// Shared types and constants for the filled-circle span generator.
package cfs_pkg;

  localparam int unsigned COORD_W  = 16;
  localparam int unsigned COLOR_W  = 16;
  localparam int unsigned RADIUS_W = 12;
  localparam int unsigned LEN_W    = 13;
  localparam int unsigned SQ_W     = 24;
  localparam int unsigned TOT_W    = 25;

  localparam logic [13:0] MAX_RADIUS = 14'd4095;

  // ceil(0.707 * 2^32); floor(r*707/1000) == (r * STEP_RECIP) >> 32 for 12-bit r
  localparam int unsigned RECIP_SHIFT = 32;
  localparam logic [31:0] STEP_RECIP =
    32'((64'd707 * 64'h1_0000_0000 + 64'd999) / 64'd1000);

  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e                cmd;
    logic [COORD_W-1:0]  cx;
    logic [COORD_W-1:0]  cy;
    logic [COLOR_W-1:0]  color;
    logic [RADIUS_W-1:0] radius;
    logic [RADIUS_W-1:0] step_limit;
    logic [SQ_W-1:0]     sq_limit;
    logic [SQ_W-1:0]     r_sq;
  } cmd_t;

endpackage

// ===== design/filled_circle_span_generator_top.sv =====
// Filled-circle span generator: front end, command queue and span sequencer.
// A start's centre span passes the front-end register, the queue, the sequencer state and the output register.
// A step issues its outer spans, if any, then its two inner spans; a start issues the centre span, an idle step none.
// The span output port moves one span per cycle while out_stall_i is low and sets that rate; the queue absorbs bursts.
// Reset (rst_ni low, async): queue empty, no circle active, no span valid.
module filled_circle_span_generator_top
  import cfs_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // item input channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                mode_i,
  input  logic [COORD_W-1:0]  center_x_i,
  input  logic [COORD_W-1:0]  center_y_i,
  input  logic [RADIUS_W-1:0] radius_i,
  input  logic [COLOR_W-1:0]  fill_color_i,
  // span output channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [COORD_W-1:0]  span_x_o,
  output logic [COORD_W-1:0]  span_y_o,
  output logic [LEN_W-1:0]    span_length_o,
  output logic [COLOR_W-1:0]  span_color_o,
  output logic                last_span_o
);

  // front end -> queue
  logic push, full;
  cmd_t push_cmd;
  // queue -> sequencer
  logic pop, empty;
  cmd_t pop_cmd;

  // Front end registers each input transfer, clamps the radius and computes
  // the step limit and squared limit for start items.
  cfs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode_i),
    .center_x_i   (center_x_i),
    .center_y_i   (center_y_i),
    .radius_i     (radius_i),
    .fill_color_i (fill_color_i),
    .full_i       (full),
    .push_o       (push),
    .push_cmd_o   (push_cmd)
  );

  // Decouples the front end from the sequencer so input transfers keep
  // flowing while a step's spans drain.
  cfs_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .pop_cmd_o  (pop_cmd),
    .empty_o    (empty)
  );

  // Sequencer owns the circle state; it decides each row step in the cycle
  // it pops the command and then issues the spans through an output register.
  cfs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (pop_cmd),
    .empty_i       (empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .span_x_o      (span_x_o),
    .span_y_o      (span_y_o),
    .span_length_o (span_length_o),
    .span_color_o  (span_color_o),
    .last_span_o   (last_span_o)
  );

endmodule

// ===== design/cfs_front.sv =====
// Front end: takes input transfers, clamps the radius and precomputes circle limits.
module cfs_front
  import cfs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                mode_i,
  input  logic [COORD_W-1:0]  center_x_i,
  input  logic [COORD_W-1:0]  center_y_i,
  input  logic [RADIUS_W-1:0] radius_i,
  input  logic [COLOR_W-1:0]  fill_color_i,
  input  logic                full_i,
  output logic                push_o,
  output cmd_t                push_cmd_o
);

  logic                s1_valid_q, s1_valid_d;
  cmd_e                s1_cmd_q;
  logic [COORD_W-1:0]  s1_cx_q, s1_cy_q;
  logic [COLOR_W-1:0]  s1_color_q;
  logic [RADIUS_W-1:0] s1_r_q;

  logic                accept;
  logic [RADIUS_W-1:0] r_sat;
  logic [RADIUS_W+RECIP_SHIFT-1:0] step_prod;
  logic [SQ_W-1:0]     r_sq;

  assign in_stall_o = s1_valid_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = s1_valid_q && !full_i;

  assign r_sat = (14'(radius_i) > MAX_RADIUS) ? MAX_RADIUS[RADIUS_W-1:0] : radius_i;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (push_o) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cmd_q   <= mode_i ? CMD_STEP : CMD_START;
      s1_cx_q    <= center_x_i;
      s1_cy_q    <= center_y_i;
      s1_color_q <= fill_color_i;
      s1_r_q     <= r_sat;
    end
  end

  // limits: r*707/1000 + 1 and r*r + r/2
  assign step_prod = (RADIUS_W+RECIP_SHIFT)'(s1_r_q) * (RADIUS_W+RECIP_SHIFT)'(STEP_RECIP);
  assign r_sq      = SQ_W'(s1_r_q) * SQ_W'(s1_r_q);

  always_comb begin
    push_cmd_o.cmd        = s1_cmd_q;
    push_cmd_o.cx         = s1_cx_q;
    push_cmd_o.cy         = s1_cy_q;
    push_cmd_o.color      = s1_color_q;
    push_cmd_o.radius     = s1_r_q;
    push_cmd_o.step_limit = step_prod[RADIUS_W+RECIP_SHIFT-1:RECIP_SHIFT] + RADIUS_W'(1);
    push_cmd_o.sq_limit   = r_sq + SQ_W'(s1_r_q >> 1);
    push_cmd_o.r_sq       = r_sq;
  end

endmodule

// ===== design/cfs_queue.sv =====
// Small command queue between the front end and the span sequencer.
module cfs_queue
  import cfs_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t pop_cmd_o,
  output logic empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o    = (count_q == CNT_W'(DEPTH));
  assign empty_o   = (count_q == '0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;
  assign pop_cmd_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ===== design/cfs_back.sv =====
// Back end: circle state, row step decision and output sequencer, one span per cycle when not stalled.
module cfs_back
  import cfs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  input  logic                empty_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [COORD_W-1:0]  span_x_o,
  output logic [COORD_W-1:0]  span_y_o,
  output logic [LEN_W-1:0]    span_length_o,
  output logic [COLOR_W-1:0]  span_color_o,
  output logic                last_span_o
);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_CENTRE  = 6'b000010,
    ST_OUTER_P = 6'b000100,
    ST_OUTER_M = 6'b001000,
    ST_INNER_P = 6'b010000,
    ST_INNER_M = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // circle state
  logic                active_q, active_d;
  logic [COORD_W-1:0]  cx_q, cy_q;
  logic [COLOR_W-1:0]  color_q;
  logic [RADIUS_W-1:0] row_q, hw_q, step_limit_q, xo_q;
  logic [SQ_W-1:0]     sq_limit_q;
  logic [TOT_W-1:0]    total_q;   // row^2 + half_width^2, kept incrementally
  logic                last_q;

  // output register
  logic                out_valid_q, out_valid_d;
  logic [COORD_W-1:0]  out_x_q, out_y_q, out_x_d, out_y_d;
  logic [LEN_W-1:0]    out_len_q, out_len_d;
  logic [COLOR_W-1:0]  out_color_q;
  logic                out_last_q, out_last_d;

  logic                out_load, can_pop, emitting;
  logic [RADIUS_W-1:0] step_i, hw_dec;
  logic [TOT_W-1:0]    tot_inc, tot_dec;
  logic                over, x_pos, is_last, outer;

  assign out_load = !out_valid_q || !out_stall_i;
  assign emitting = (state_q != ST_IDLE);
  assign can_pop  = (state_q == ST_IDLE) ||
                    (out_load && ((state_q == ST_CENTRE) || (state_q == ST_INNER_M)));
  assign pop_o    = can_pop && !empty_i;

  // row step decision
  assign step_i  = row_q + RADIUS_W'(1);
  assign tot_inc = total_q + {{(TOT_W-RADIUS_W-1){1'b0}}, row_q, 1'b1};
  assign over    = tot_inc > {1'b0, sq_limit_q};
  assign x_pos   = (hw_q != '0);
  assign hw_dec  = hw_q - RADIUS_W'(1);
  assign tot_dec = tot_inc - {{(TOT_W-RADIUS_W-1){1'b0}}, hw_dec, 1'b1};
  assign is_last = (step_i >= step_limit_q);
  assign outer   = over && (hw_q > step_limit_q);

  always_comb begin
    state_d  = state_q;
    active_d = active_q;
    case (state_q)
      ST_IDLE:    state_d = ST_IDLE;
      ST_CENTRE:  if (out_load) state_d = ST_IDLE;
      ST_OUTER_P: if (out_load) state_d = ST_OUTER_M;
      ST_OUTER_M: if (out_load) state_d = ST_INNER_P;
      ST_INNER_P: if (out_load) state_d = ST_INNER_M;
      ST_INNER_M: if (out_load) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
    if (pop_o) begin
      if (cmd_i.cmd == CMD_START) begin
        state_d  = ST_CENTRE;
        active_d = 1'b1;
      end else if (active_q) begin
        state_d = outer ? ST_OUTER_P : ST_INNER_P;
        if (is_last) begin
          active_d = 1'b0;
        end
      end else begin
        state_d = ST_IDLE;
      end
    end
  end

  // span fields from the current state
  always_comb begin
    out_x_d    = cx_q - COORD_W'(hw_q);
    out_y_d    = cy_q;
    out_len_d  = {hw_q, 1'b0};
    out_last_d = 1'b0;
    case (state_q)
      ST_OUTER_P: begin
        out_x_d   = cx_q - COORD_W'(row_q) + COORD_W'(1);
        out_y_d   = cy_q + COORD_W'(xo_q);
        out_len_d = {row_q - RADIUS_W'(1), 1'b0};
      end
      ST_OUTER_M: begin
        out_x_d   = cx_q - COORD_W'(row_q) + COORD_W'(1);
        out_y_d   = cy_q - COORD_W'(xo_q);
        out_len_d = {row_q - RADIUS_W'(1), 1'b0};
      end
      ST_INNER_P: out_y_d = cy_q + COORD_W'(row_q);
      ST_INNER_M: begin
        out_y_d    = cy_q - COORD_W'(row_q);
        out_last_d = last_q;
      end
      default: out_y_d = cy_q;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = emitting;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      if (cmd_i.cmd == CMD_START) begin
        cx_q         <= cmd_i.cx;
        cy_q         <= cmd_i.cy;
        color_q      <= cmd_i.color;
        row_q        <= '0;
        hw_q         <= cmd_i.radius;
        step_limit_q <= cmd_i.step_limit;
        sq_limit_q   <= cmd_i.sq_limit;
        total_q      <= {1'b0, cmd_i.r_sq};
        last_q       <= 1'b0;
      end else if (active_q) begin
        row_q  <= step_i;
        xo_q   <= hw_q;
        last_q <= is_last;
        if (over && x_pos) begin
          hw_q    <= hw_dec;
          total_q <= tot_dec;
        end else begin
          total_q <= tot_inc;
        end
      end
    end
    if (out_load && emitting) begin
      out_x_q     <= out_x_d;
      out_y_q     <= out_y_d;
      out_len_q   <= out_len_d;
      out_color_q <= color_q;
      out_last_q  <= out_last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign span_x_o      = out_x_q;
  assign span_y_o      = out_y_q;
  assign span_length_o = out_len_q;
  assign span_color_o  = out_color_q;
  assign last_span_o   = out_last_q;

endmodule

// ===== test/filled_circle_span_generator_top_test.sv =====
// Self-checking testbench for the filled-circle span generator: directed and random circles, scoreboard check.
module filled_circle_span_generator_top_test;
  import cfs_pkg::*;

  // One input transfer as the sender sees it.
  typedef struct packed {
    cmd_e                cmd;
    logic [COORD_W-1:0]  cx;
    logic [COORD_W-1:0]  cy;
    logic [RADIUS_W-1:0] radius;
    logic [COLOR_W-1:0]  color;
  } circle_item_t;

  // One span transfer on the output channel.
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [LEN_W-1:0]   len;
    logic [COLOR_W-1:0] color;
    logic               last;
  } span_t;

  // Span ledger: keeps its own copy of the rasterizer state, expands every
  // accepted item into the spans it should produce, and checks each span
  // that leaves the block against the oldest one still owed.
  class span_ledger;
    span_t                spans_due[$];
    int unsigned          mismatches;
    bit                   busy;
    logic [COORD_W-1:0]   org_x;
    logic [COORD_W-1:0]   org_y;
    logic [COLOR_W-1:0]   ink;
    int unsigned          row;
    int unsigned          half;
    int unsigned          lim_step;
    int unsigned          lim_sq;

    function new();
      spans_due.delete();
      mismatches = 0;
      busy = 1'b0;
      org_x = '0;
      org_y = '0;
      ink = '0;
      row = 0;
      half = 0;
      lim_step = 0;
      lim_sq = 0;
    endfunction

    function void owe(int unsigned sx, int unsigned sy, int unsigned slen, bit slast);
      span_t s;
      s.x = COORD_W'(sx);
      s.y = COORD_W'(sy);
      s.len = LEN_W'(slen);
      s.color = ink;
      s.last = slast;
      spans_due.push_back(s);
    endfunction

    function void note_item(circle_item_t it);
      int unsigned r;
      int unsigned i;
      int unsigned x;
      bit fin;
      if (it.cmd == CMD_START) begin
        // a start always restarts, abandoning any circle in flight
        r = it.radius;
        if (r > MAX_RADIUS) r = MAX_RADIUS;
        org_x = it.cx;
        org_y = it.cy;
        ink = it.color;
        row = 0;
        half = r;
        lim_step = (r * 707) / 1000 + 1;
        lim_sq = r * r + r / 2;
        busy = 1'b1;
        owe(org_x - r, org_y, 2 * r, 1'b0);
        return;
      end
      if (!busy) return;
      row = row + 1;
      i = row;
      x = half;
      fin = (i >= lim_step);
      if (i * i + x * x > lim_sq) begin
        if (x > lim_step) begin
          owe(org_x - i + 1, org_y + x, 2 * (i - 1), 1'b0);
          owe(org_x - i + 1, org_y - x, 2 * (i - 1), 1'b0);
        end
        if (x > 0) x = x - 1;
        half = x;
      end
      owe(org_x - x, org_y + i, 2 * x, 1'b0);
      owe(org_x - x, org_y - i, 2 * x, fin);
      if (fin) busy = 1'b0;
    endfunction

    function void check_span(span_t got);
      span_t want;
      if (spans_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected span: x=%h y=%h len=%0d col=%h last=%b",
                   got.x, got.y, got.len, got.color, got.last);
        return;
      end
      want = spans_due.pop_front();
      if (got.x !== want.x || got.y !== want.y || got.len !== want.len ||
          got.color !== want.color || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"span mismatch: exp x=%h y=%h len=%0d col=%h last=%b,",
                    " got x=%h y=%h len=%0d col=%h last=%b"},
                   want.x, want.y, want.len, want.color, want.last,
                   got.x, got.y, got.len, got.color, got.last);
      end
    endfunction

    function int unsigned pending();
      return spans_due.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic                mode_i;
  logic [COORD_W-1:0]  center_x_i;
  logic [COORD_W-1:0]  center_y_i;
  logic [RADIUS_W-1:0] radius_i;
  logic [COLOR_W-1:0]  fill_color_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [COORD_W-1:0]  span_x_o;
  logic [COORD_W-1:0]  span_y_o;
  logic [LEN_W-1:0]    span_length_o;
  logic [COLOR_W-1:0]  span_color_o;
  logic                last_span_o;

  span_ledger  ledger;
  int unsigned items_sent;
  // while set, neither side inserts gaps: back-to-back stretches
  bit          calm;

  filled_circle_span_generator_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode_i),
    .center_x_i   (center_x_i),
    .center_y_i   (center_y_i),
    .radius_i     (radius_i),
    .fill_color_i (fill_color_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .span_x_o     (span_x_o),
    .span_y_o     (span_y_o),
    .span_length_o(span_length_o),
    .span_color_o (span_color_o),
    .last_span_o  (last_span_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop: reports failure and ends the run if it is still going.
  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Gap length for either side: mostly none, often short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm) return 0;
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // Output monitor: a span transfer completes at a rising edge with valid
  // high and stall low. Stall only moves on falling edges, so this is stable.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      ledger.check_span({span_x_o, span_y_o, span_length_o, span_color_o, last_span_o});
  end

  // Receiver back-pressure: stall bursts of random length between open windows.
  initial begin
    int unsigned hold;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      hold = pick_gap();
      if (hold > 0) begin
        out_stall_i = 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i = 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk_i);
    end
  end

  // Called at a falling edge. Drops valid for a random gap, then presents the
  // item and holds it until the transfer; returns at the following falling edge.
  task automatic send_item(input circle_item_t it);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    mode_i       = it.cmd;
    center_x_i   = it.cx;
    center_y_i   = it.cy;
    radius_i     = it.radius;
    fill_color_i = it.color;
    in_valid_i   = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    ledger.note_item(it);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic start_circle(input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy,
                              input logic [RADIUS_W-1:0] sr, input logic [COLOR_W-1:0] sc);
    circle_item_t it;
    it.cmd = CMD_START;
    it.cx = sx;
    it.cy = sy;
    it.radius = sr;
    it.color = sc;
    send_item(it);
  endtask

  // Step items carry random junk in the fields the block must ignore.
  task automatic step_rows(input int unsigned count);
    circle_item_t it;
    repeat (count) begin
      it.cmd = CMD_STEP;
      it.cx = COORD_W'($urandom());
      it.cy = COORD_W'($urandom());
      it.radius = RADIUS_W'($urandom());
      it.color = COLOR_W'($urandom());
      send_item(it);
    end
  endtask

  // Sender holds off until every owed span has come out.
  task automatic drain();
    in_valid_i = 1'b0;
    while (ledger.pending() != 0) @(negedge clk_i);
  endtask

  initial begin
    circle_item_t it;
    int unsigned  r;
    int unsigned  full;
    int unsigned  n;
    int unsigned  roll;

    ledger       = new();
    items_sent   = 0;
    calm         = 1'b0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    mode_i       = 1'b0;
    center_x_i   = '0;
    center_y_i   = '0;
    radius_i     = '0;
    fill_color_i = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // ---- directed part ----
    // step with no circle running: no spans
    step_rows(1);
    // radius zero at the origin: zero-length spans, one step finishes it
    start_circle(16'h0000, 16'h0000, 12'd0, 16'h0000);
    step_rows(1);
    // idle again after the last span
    step_rows(1);
    // radius one at the top corner: coordinates wrap past 65535
    start_circle(16'hFFFF, 16'hFFFF, 12'd1, 16'hFFFF);
    step_rows(1);
    // largest radius, a few rows, then abandoned by a fresh start
    start_circle(16'h8000, 16'h7FFF, 12'hFFF, 16'hAAAA);
    step_rows(4);
    // radius 7 runs to completion; row 2 already emits outer spans
    start_circle(COORD_W'($urandom()), COORD_W'($urandom()), 12'd7, COLOR_W'($urandom()));
    step_rows(5);
    // partial circle, then a tiny one near zero so cx-r and cy minus the row wrap
    start_circle(16'h1234, 16'h4321, 12'd10, 16'h5555);
    step_rows(2);
    start_circle(16'h0001, 16'h0000, 12'd2, 16'h00FF);
    step_rows(2);
    drain();

    // ---- random part ----
    // Mostly whole circles with small radii; some cut short, some followed
    // by idle steps, a few huge ones that get abandoned, plus raw noise.
    while (items_sent < 195) begin
      calm = ($urandom_range(0, 4) == 0);
      roll = $urandom_range(0, 99);
      if (roll < 80) begin
        if ($urandom_range(0, 19) == 0) r = $urandom_range(41, 4095);
        else r = $urandom_range(0, 40);
        full = (r * 707) / 1000 + 1;
        roll = $urandom_range(0, 99);
        if (r > 40) n = $urandom_range(1, 12);
        else if (roll < 15) n = $urandom_range(0, full - 1);
        else if (roll < 25) n = full + $urandom_range(1, 3);
        else n = full;
        start_circle(COORD_W'($urandom()), COORD_W'($urandom()), RADIUS_W'(r),
                     COLOR_W'($urandom()));
        step_rows(n);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          it.cmd = $urandom_range(0, 3) == 0 ? CMD_START : CMD_STEP;
          it.cx = COORD_W'($urandom());
          it.cy = COORD_W'($urandom());
          it.radius = $urandom_range(0, 3) == 0 ? RADIUS_W'($urandom()) :
                                                 RADIUS_W'($urandom_range(0, 20));
          it.color = COLOR_W'($urandom());
          send_item(it);
        end
      end
      if ($urandom_range(0, 99) < 8) drain();
    end

    // ---- wind down ----
    calm = 1'b0;
    in_valid_i = 1'b0;
    while (ledger.pending() != 0) @(negedge clk_i);
    // a trailing idle step could still be in the pipe; let it settle
    repeat (20) @(posedge clk_i);

    if (ledger.pending() != 0)
      $display("%0d spans never arrived", ledger.pending());
    if (ledger.mismatches == 0 && ledger.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/cfs_pkg.sv
design/cfs_front.sv
design/cfs_queue.sv
design/cfs_back.sv
design/filled_circle_span_generator_top.sv
test/filled_circle_span_generator_top_test.sv
